>>> hdl/hrf_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP request framer: section and event codes, line flag bits
// and the method and field-name text tables. No dependencies.
package hrf_pkg;

   typedef enum logic [2:0] {
      SEC_METHOD  = 3'd0,
      SEC_PATH    = 3'd1,
      SEC_VERSION = 3'd2,
      SEC_NAME    = 3'd3,
      SEC_VALUE   = 3'd4,
      SEC_BODY    = 3'd5,
      SEC_ERROR   = 3'd6
   } section_type;

   typedef enum logic [2:0] {
      EV_HEADER    = 3'd0,
      EV_DONE      = 3'd1,
      EV_HDR_BODY  = 3'd2,
      EV_BODY      = 3'd3,
      EV_BODY_LAST = 3'd4,
      EV_ERROR     = 3'd5,
      EV_DROPPED   = 3'd6
   } event_type;

   localparam int FL_NAME  = 0;
   localparam int FL_START = 1;
   localparam int FL_DIGIT = 2;
   localparam int FL_DONE  = 3;
   localparam int FL_NEG   = 4;
   localparam int FL_OVF   = 5;

   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_COLON = 8'h3A;
   localparam logic [7:0] BYTE_PLUS  = 8'h2B;
   localparam logic [7:0] BYTE_MINUS = 8'h2D;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;
   localparam logic [7:0] BYTE_UC_A  = 8'h41;
   localparam logic [7:0] BYTE_UC_Z  = 8'h5A;

   localparam int METHODS = 9;
   localparam int CL_LEN  = 14;

   localparam logic [3:0] METH_LEN [METHODS] = '{
      4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5};

   localparam logic [7:0] METH_TEXT [METHODS][8] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}};

   localparam logic [7:0] CL_TEXT [16] = '{
      "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h",
      8'h00, 8'h00};

endpackage

>>> hdl/http_request_framer_top.sv
`timescale 1ns / 1ps
// HTTP request framer: header end detection, method decode, content-length
// parse and body count, one byte per item. Depends on hrf_pkg.
//
//  channel | dir | ports                                         | handshake
//  req     | in  | req_data_byte                                 | req_valid / req_ready
//  rsp     | out | rsp_event_res rsp_out_byte rsp_method_code
//          |     | rsp_body_length                               | rsp_valid / rsp_ready
//
// One item per cycle unless rsp stalls; the result appears in the output
// register in the cycle after acceptance. req_ready is high when that register
// is empty or being taken, so a stall on rsp holds off req only while a result
// waits. Synchronous active-high reset clears parser state and the output valid.
module http_request_framer_top import hrf_pkg::*; #(
   parameter int LENGTH_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_method_code,
   output logic [30:0] rsp_body_length
);

   localparam int AW = LENGTH_BITS + 1;
   localparam int MW = LENGTH_BITS + 5;
   localparam logic [AW-1:0] ACC_CAP = AW'(1) << LENGTH_BITS;
   localparam logic [AW-1:0] LEN_MAX = ACC_CAP - AW'(1);

   typedef struct packed {
      logic                   crlf;
      section_type            section;
      logic [METHODS-1:0]     cand;
      logic [3:0]             tpos;
      logic [5:0]             flags;
      logic [AW-1:0]          acc;
      logic [LENGTH_BITS-1:0] decl;
      logic [LENGTH_BITS-1:0] rem;
   } state_type;

   function automatic state_type fresh();
      state_type s;
      s.crlf    = 1'b0;
      s.section = SEC_METHOD;
      s.cand    = '1;
      s.tpos    = '0;
      s.flags   = '0;
      s.acc     = '0;
      s.decl    = '0;
      s.rem     = '0;
      return s;
   endfunction

   function automatic state_type content_byte(state_type si, logic [7:0] b);
      state_type          s;
      logic [METHODS-1:0] m;
      logic [7:0]         lo;
      logic [MW-1:0]      nv;
      logic               is_cl;
      s = si;
      m = '0;
      unique case (si.section)
         SEC_METHOD: begin
            if (b == BYTE_SPACE) begin
               for (int i = 0; i < METHODS; i++)
                  m[i] = si.cand[i] && (METH_LEN[i] == si.tpos);
               if (m == '0) begin
                  s.section = SEC_ERROR;
               end else begin
                  s.cand    = m;
                  s.section = SEC_PATH;
                  s.tpos    = '0;
               end
            end else begin
               for (int i = 0; i < METHODS; i++)
                  if (si.tpos >= METH_LEN[i] || METH_TEXT[i][si.tpos[2:0]] != b)
                     s.cand[i] = 1'b0;
               if (si.tpos != 4'd15) s.tpos = si.tpos + 4'd1;
            end
         end
         SEC_PATH: begin
            if (b == BYTE_SPACE) s.section = SEC_VERSION;
         end
         SEC_NAME: begin
            if (b == BYTE_COLON) begin
               is_cl     = si.flags[FL_NAME] && (si.tpos == 4'(CL_LEN));
               s.flags   = '0;
               s.flags[FL_NAME] = is_cl;
               s.acc     = '0;
               s.section = SEC_VALUE;
            end else begin
               lo = (b >= BYTE_UC_A && b <= BYTE_UC_Z) ? b + 8'd32 : b;
               if (si.tpos >= 4'(CL_LEN) || CL_TEXT[si.tpos] != lo)
                  s.flags[FL_NAME] = 1'b0;
               if (si.tpos != 4'd15) s.tpos = si.tpos + 4'd1;
            end
         end
         SEC_VALUE: begin
            if (!si.flags[FL_DONE]) begin
               priority if (!si.flags[FL_START] && (b == BYTE_SPACE || b == BYTE_TAB)) begin
               end else if (!si.flags[FL_START] && b == BYTE_PLUS) begin
                  s.flags[FL_START] = 1'b1;
               end else if (!si.flags[FL_START] && b == BYTE_MINUS) begin
                  s.flags[FL_START] = 1'b1;
                  s.flags[FL_NEG]   = 1'b1;
               end else if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
                  s.flags[FL_START] = 1'b1;
                  s.flags[FL_DIGIT] = 1'b1;
                  nv = MW'(si.acc) * MW'(10) + MW'(b - BYTE_ZERO);
                  if (nv > MW'(ACC_CAP)) begin
                     s.acc = ACC_CAP;
                     s.flags[FL_OVF] = 1'b1;
                  end else begin
                     s.acc = nv[AW-1:0];
                  end
               end else begin
                  s.flags[FL_START] = 1'b1;
                  s.flags[FL_DONE]  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   state_type        state_ff, state_in;
   event_type        ev;
   logic [3:0]       mc;
   logic [30:0]      bl;
   logic             rsp_valid_ff;
   logic [2:0]       event_ff;
   logic [7:0]       byte_ff;
   logic [3:0]       method_ff;
   logic [30:0]      length_ff;
   logic             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_type s;
      s  = state_ff;
      ev = EV_HEADER;
      mc = '0;
      bl = '0;
      if (state_ff.section == SEC_ERROR) begin
         ev = EV_DROPPED;
      end else if (state_ff.section == SEC_BODY) begin
         if (state_ff.rem <= LENGTH_BITS'(1)) begin
            s.rem = '0;
            ev    = EV_BODY_LAST;
         end else begin
            s.rem = state_ff.rem - LENGTH_BITS'(1);
            ev    = EV_BODY;
         end
      end else begin
         if (state_ff.crlf) begin
            s.crlf = 1'b0;
            if (req_data_byte == BYTE_LF) begin
               unique case (state_ff.section)
                  SEC_VERSION: begin
                     s.section = SEC_NAME;
                     s.tpos    = '0;
                     s.flags   = '0;
                     s.flags[FL_NAME] = 1'b1;
                     s.acc     = '0;
                  end
                  SEC_NAME: begin
                     if (state_ff.tpos != '0) begin
                        s.section = SEC_ERROR;
                     end else if (state_ff.decl != '0) begin
                        s.section = SEC_BODY;
                        s.rem     = state_ff.decl;
                        ev        = EV_HDR_BODY;
                     end else begin
                        ev = EV_DONE;
                     end
                  end
                  SEC_VALUE: begin
                     s.section = SEC_NAME;
                     s.tpos    = '0;
                     s.flags   = '0;
                     s.flags[FL_NAME] = 1'b1;
                     s.acc     = '0;
                     if (state_ff.flags[FL_NAME]) begin
                        priority if (!state_ff.flags[FL_DIGIT] || state_ff.flags[FL_OVF]) begin
                           s.section = SEC_ERROR;
                        end else if (state_ff.flags[FL_NEG]) begin
                           s.decl = '0;
                        end else if (state_ff.acc > LEN_MAX) begin
                           s.section = SEC_ERROR;
                        end else begin
                           s.decl = state_ff.acc[LENGTH_BITS-1:0];
                        end
                     end
                  end
                  default: begin
                     s.section = SEC_ERROR;
                  end
               endcase
            end else begin
               s = content_byte(s, BYTE_CR);
               if (s.section != SEC_ERROR) begin
                  if (req_data_byte == BYTE_CR) s.crlf = 1'b1;
                  else s = content_byte(s, req_data_byte);
               end
            end
         end else if (req_data_byte == BYTE_CR) begin
            s.crlf = 1'b1;
         end else begin
            s = content_byte(s, req_data_byte);
         end
         if (s.section == SEC_ERROR) ev = EV_ERROR;
      end
      if (ev != EV_ERROR && ev != EV_DROPPED) begin
         if (s.section >= SEC_PATH && s.section <= SEC_BODY) begin
            for (int i = METHODS - 1; i >= 0; i--)
               if (s.cand[i]) mc = 4'(i);
         end
         bl = 31'(s.decl);
      end
      if (ev == EV_DONE || ev == EV_BODY_LAST) s = fresh();
      state_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fresh();
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= ev;
         byte_ff   <= req_data_byte;
         method_ff <= mc;
         length_ff <= bl;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = event_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_method_code = method_ff;
   assign rsp_body_length = length_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output valid after reset");
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.section == SEC_ERROR |=> state_ff.section == SEC_ERROR)
      else $error("error state left");
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.section == SEC_BODY |-> state_ff.rem != '0)
      else $error("body section with zero count");
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (event_ff == EV_ERROR || event_ff == EV_DROPPED)
      |-> method_ff == '0 && length_ff == '0)
      else $error("error item carries fields");

endmodule
